// ----- hdl/pmcs_pkg.sv -----
// shared types, constants and reset values for the pressure matrix conditioner
`timescale 1ns / 1ps
`default_nettype none

package pmcs_pkg;

  // default geometry and calibration length
  localparam int ROWS_DEFAULT        = 15;
  localparam int COLS_DEFAULT        = 15;
  localparam int CAL_FRAMES_DEFAULT  = 50;
  localparam int SAMPLE_BITS_DEFAULT = 12;

  // fixed field widths
  localparam int SAMPLE_W = 12;
  localparam int POS_W    = 4;
  localparam int LEVEL_W  = 8;
  localparam int STORE_W  = 18;
  localparam int FRAME_W  = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_VAL_W = 12;

  // shared divider widths: numerator covers the map product, denominator the map range
  localparam int DIV_NUM_W = 26;
  localparam int DIV_DEN_W = 12;

  // register reset values
  localparam logic [SAMPLE_W-1:0] SAT_LIMIT_RESET      = 12'd1600;
  localparam logic [LEVEL_W-1:0]  ZERO_THRESHOLD_RESET = 8'd150;
  localparam logic [LEVEL_W-1:0]  OUT_LOW_RESET        = 8'd1;
  localparam logic [LEVEL_W-1:0]  OUT_HIGH_RESET       = 8'd254;
  localparam logic [LEVEL_W-1:0]  GLOBAL_MIN_RESET     = 8'd254;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAT_LIMIT      = 3'd0,
    REG_ZERO_THRESHOLD = 3'd1,
    REG_OUT_LOW        = 3'd2,
    REG_OUT_HIGH       = 3'd3
  } cfg_reg_t;

  // sample mode codes
  localparam logic MODE_CAL  = 1'b0;
  localparam logic MODE_MEAS = 1'b1;

  // channel payloads
  typedef struct packed {
    logic                mode;
    logic [POS_W-1:0]    row;
    logic [POS_W-1:0]    column;
    logic [SAMPLE_W-1:0] sample;
  } sample_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
  } level_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_VAL_W-1:0] value;
  } cfg_t;

  // divider request and response
  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_LOAD,
    S_MUL,
    S_DIV_CAL,
    S_DIV_MAP,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

// ----- hdl/pmcs_stream_if.sv -----
// valid/ready channel carrying one payload item
`timescale 1ns / 1ps
`default_nettype none

interface pmcs_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/pmcs_ram.sv -----
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps
`default_nettype none

module pmcs_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 225,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hdl/pmcs_div.sv -----
// unsigned restoring divider, two quotient bits per cycle
`timescale 1ns / 1ps
`default_nettype none

module pmcs_div (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire pmcs_pkg::div_req_t  req,
  output pmcs_pkg::div_rsp_t       rsp
);

  localparam int NUM_W  = pmcs_pkg::DIV_NUM_W;
  localparam int DEN_W  = pmcs_pkg::DIV_DEN_W;
  localparam int STEPS  = (NUM_W + 1) / 2;
  localparam int WORK_W = 2 * STEPS;
  localparam int CNT_W  = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [DEN_W:0]    rem;
  logic [WORK_W-1:0] quo;
  logic [DEN_W-1:0]  den;
  logic [DEN_W:0]    rem_next;
  logic [WORK_W-1:0] quo_next;

  // two shift-compare-subtract steps
  always_comb begin
    rem_next = rem;
    quo_next = quo;
    for (int k = 0; k < 2; k++) begin
      rem_next = {rem_next[DEN_W-1:0], quo_next[WORK_W-1]};
      quo_next = {quo_next[WORK_W-2:0], 1'b0};
      if (rem_next >= {1'b0, den}) begin
        rem_next    = rem_next - {1'b0, den};
        quo_next[0] = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // operands and partial results
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= WORK_W'(req.num);
      den <= req.den;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo[NUM_W-1:0];

endmodule

`default_nettype wire

// ----- hdl/pressure_matrix_calibrate_and_scale.sv -----
// top level: per-cell baseline calibration and linear level mapping
//
// Samples from a ROWS by COLS pressure matrix arrive one item at a time on
// the samples channel; the block handles one item at a time. Cell sums and
// baselines live in one ram with a registered read, with a valid bit per
// cell so the store reads as zero after reset without a clearing pass. A
// calibration item (mode 0) passes ram read and load and writes its sum; in
// the last calibration frame the shared divider forms the baseline to write.
// A measurement item (mode 1) passes ram read, multiply, the divider at two
// quotient bits per cycle (skipped for a zero map range) and the output
// register once it is free. Items with a row or column outside the matrix,
// and calibration items once CAL_FRAMES frames are done, are taken and produce
// nothing. The next item is accepted while a level still waits on the levels
// channel. Configuration writes are always accepted and take effect at once.
`timescale 1ns / 1ps
`default_nettype none

module pressure_matrix_calibrate_and_scale #(
  parameter int ROWS        = pmcs_pkg::ROWS_DEFAULT,
  parameter int COLS        = pmcs_pkg::COLS_DEFAULT,
  parameter int CAL_FRAMES  = pmcs_pkg::CAL_FRAMES_DEFAULT,
  parameter int SAMPLE_BITS = pmcs_pkg::SAMPLE_BITS_DEFAULT
) (
  input wire logic     clk,
  input wire logic     rst,
  pmcs_stream_if.sink   samples,
  pmcs_stream_if.source levels,
  pmcs_stream_if.sink   cfg
);

  localparam int SAMPLE_W = pmcs_pkg::SAMPLE_W;
  localparam int LEVEL_W  = pmcs_pkg::LEVEL_W;
  localparam int STORE_W  = pmcs_pkg::STORE_W;
  localparam int FRAME_W  = pmcs_pkg::FRAME_W;
  localparam int POS_W    = pmcs_pkg::POS_W;
  localparam int NUM_W    = pmcs_pkg::DIV_NUM_W;
  localparam int DEN_W    = pmcs_pkg::DIV_DEN_W;
  localparam int MVAL_W   = NUM_W + 2;
  localparam int CELLS    = ROWS * COLS;
  localparam int ADDR_W   = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int IDX_W    = 2 * POS_W + 1;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
    SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);

  // configuration registers
  logic [SAMPLE_W-1:0] sat_limit;
  logic [LEVEL_W-1:0]  zero_threshold;
  logic [LEVEL_W-1:0]  out_low;
  logic [LEVEL_W-1:0]  out_high;

  // block state
  pmcs_pkg::state_t state;
  pmcs_pkg::state_t state_next;
  logic [FRAME_W-1:0] frame_count;
  logic [LEVEL_W-1:0] global_minimum;
  logic [CELLS-1:0]   cell_valid;

  // item in flight
  logic                it_mode;
  logic [SAMPLE_W-1:0] it_sample;
  logic [ADDR_W-1:0]   it_addr;
  logic                it_last;

  // map operands
  logic               diff_neg;
  logic [STORE_W-1:0] diff_mag;
  logic               scale_neg;
  logic [LEVEL_W-1:0] scale_mag;
  logic               den_neg;
  logic               den_zero;
  logic [DEN_W-1:0]   den_mag;
  logic [MVAL_W-1:0]  mval;

  // output register
  logic               out_valid;
  logic [LEVEL_W-1:0] out_level;

  // ram and divider
  logic               ram_we;
  logic [STORE_W-1:0] ram_wdata;
  logic [STORE_W-1:0] ram_q;
  pmcs_pkg::div_req_t div_req;
  pmcs_pkg::div_rsp_t div_rsp;

  pmcs_ram #(
    .WIDTH (STORE_W),
    .DEPTH (CELLS)
  ) u_cell_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (it_addr),
    .wdata (ram_wdata),
    .raddr (it_addr),
    .rdata (ram_q)
  );

  pmcs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // input decode
  logic               in_range;
  logic [IDX_W-1:0]   in_index;
  logic               in_last;
  logic               cal_done;
  logic               in_go;
  logic               in_accept;

  assign in_range = ({1'b0, samples.data.row} < (POS_W + 1)'(ROWS)) &&
                    ({1'b0, samples.data.column} < (POS_W + 1)'(COLS));
  assign in_index = IDX_W'(samples.data.row) * IDX_W'(COLS) + IDX_W'(samples.data.column);
  assign in_last  = ({1'b0, samples.data.row} == (POS_W + 1)'(ROWS - 1)) &&
                    ({1'b0, samples.data.column} == (POS_W + 1)'(COLS - 1));
  assign cal_done = frame_count >= FRAME_W'(CAL_FRAMES);
  assign in_go    = in_range && ((samples.data.mode == pmcs_pkg::MODE_MEAS) || !cal_done);
  assign in_accept = samples.valid && samples.ready;

  // stored value of the cell, zero until first written
  logic [STORE_W-1:0] stored;
  logic [STORE_W-1:0] cal_sum;
  logic               last_frame;
  logic [SAMPLE_W-1:0] clipped;
  logic [STORE_W-1:0] raised;
  logic [STORE_W:0]   diff;
  logic [LEVEL_W:0]   scale;
  logic [DEN_W:0]     den;
  logic [STORE_W-1:0] base;

  assign stored     = cell_valid[it_addr] ? ram_q : '0;
  assign cal_sum    = stored + STORE_W'(it_sample);
  assign last_frame = frame_count == FRAME_W'(CAL_FRAMES - 1);
  assign clipped    = (it_sample > sat_limit) ? sat_limit : it_sample;
  assign raised     = (stored > STORE_W'(clipped)) ? stored : STORE_W'(clipped);
  assign diff       = {1'b0, raised} - (STORE_W + 1)'(global_minimum);
  assign scale      = {1'b0, out_high} - {1'b0, out_low};
  assign den        = {1'b0, sat_limit} - (DEN_W + 1)'(global_minimum);
  assign base       = div_rsp.quo[STORE_W-1:0];

  // signed quotient plus offset, then threshold and clamp
  logic [MVAL_W-1:0]  quo_signed;
  logic [MVAL_W-1:0]  map_value;
  logic               below_thr;
  logic               above_high;
  logic [LEVEL_W-1:0] level_value;

  assign quo_signed  = (diff_neg ^ scale_neg ^ den_neg) ? -MVAL_W'(div_rsp.quo)
                                                        : MVAL_W'(div_rsp.quo);
  assign map_value   = quo_signed + MVAL_W'(out_low);
  assign below_thr   = mval[MVAL_W-1] || (mval[MVAL_W-2:0] < (MVAL_W - 1)'(zero_threshold));
  assign above_high  = !mval[MVAL_W-1] && (mval[MVAL_W-2:0] > (MVAL_W - 1)'(out_high));
  assign level_value = below_thr ? '0 : (above_high ? out_high : mval[LEVEL_W-1:0]);

  logic out_free;
  assign out_free = !out_valid || levels.ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pmcs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, ram write and divider start
  always_comb begin
    state_next    = state;
    samples.ready = 1'b0;
    ram_we        = 1'b0;
    ram_wdata     = cal_sum;
    div_req.start = 1'b0;
    div_req.num   = NUM_W'(cal_sum);
    div_req.den   = DEN_W'(CAL_FRAMES);
    case (state)
      pmcs_pkg::S_IDLE: begin
        samples.ready = 1'b1;
        if (samples.valid && in_go) begin
          state_next = pmcs_pkg::S_READ;
        end
      end
      pmcs_pkg::S_READ: begin
        state_next = pmcs_pkg::S_LOAD;
      end
      pmcs_pkg::S_LOAD: begin
        if (it_mode == pmcs_pkg::MODE_MEAS) begin
          state_next = pmcs_pkg::S_MUL;
        end else if (last_frame) begin
          div_req.start = 1'b1;
          state_next    = pmcs_pkg::S_DIV_CAL;
        end else begin
          ram_we     = 1'b1;
          state_next = pmcs_pkg::S_IDLE;
        end
      end
      pmcs_pkg::S_MUL: begin
        div_req.num = NUM_W'(diff_mag * scale_mag);
        div_req.den = den_mag;
        if (den_zero) begin
          state_next = pmcs_pkg::S_EMIT;
        end else begin
          div_req.start = 1'b1;
          state_next    = pmcs_pkg::S_DIV_MAP;
        end
      end
      pmcs_pkg::S_DIV_CAL: begin
        ram_wdata = base;
        if (div_rsp.done) begin
          ram_we     = 1'b1;
          state_next = pmcs_pkg::S_IDLE;
        end
      end
      pmcs_pkg::S_DIV_MAP: begin
        if (div_rsp.done) begin
          state_next = pmcs_pkg::S_EMIT;
        end
      end
      pmcs_pkg::S_EMIT: begin
        if (out_free) begin
          state_next = pmcs_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pmcs_pkg::S_IDLE;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sat_limit      <= pmcs_pkg::SAT_LIMIT_RESET;
      zero_threshold <= pmcs_pkg::ZERO_THRESHOLD_RESET;
      out_low        <= pmcs_pkg::OUT_LOW_RESET;
      out_high       <= pmcs_pkg::OUT_HIGH_RESET;
    end else if (cfg.valid) begin
      case (pmcs_pkg::cfg_reg_t'(cfg.data.index))
        pmcs_pkg::REG_SAT_LIMIT:      sat_limit      <= cfg.data.value[SAMPLE_W-1:0];
        pmcs_pkg::REG_ZERO_THRESHOLD: zero_threshold <= cfg.data.value[LEVEL_W-1:0];
        pmcs_pkg::REG_OUT_LOW:        out_low        <= cfg.data.value[LEVEL_W-1:0];
        pmcs_pkg::REG_OUT_HIGH:       out_high       <= cfg.data.value[LEVEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.ready = 1'b1;

  // calibration state: valid bits, frame count, global minimum
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid     <= '0;
      frame_count    <= '0;
      global_minimum <= pmcs_pkg::GLOBAL_MIN_RESET;
    end else if (ram_we) begin
      cell_valid[it_addr] <= 1'b1;
      if (it_last) begin
        frame_count <= frame_count + 1'b1;
      end
      if (state == pmcs_pkg::S_DIV_CAL && base < STORE_W'(global_minimum)) begin
        global_minimum <= base[LEVEL_W-1:0];
      end
    end
  end

  // item capture and map datapath
  always_ff @(posedge clk) begin
    if (in_accept) begin
      it_mode   <= samples.data.mode;
      it_sample <= samples.data.sample & SAMPLE_MASK;
      it_addr   <= in_index[ADDR_W-1:0];
      it_last   <= in_last;
    end
    if (state == pmcs_pkg::S_LOAD) begin
      diff_neg  <= diff[STORE_W];
      diff_mag  <= diff[STORE_W] ? STORE_W'(-diff) : diff[STORE_W-1:0];
      scale_neg <= scale[LEVEL_W];
      scale_mag <= scale[LEVEL_W] ? LEVEL_W'(-scale) : scale[LEVEL_W-1:0];
      den_neg   <= den[DEN_W];
      den_zero  <= den == '0;
      den_mag   <= den[DEN_W] ? DEN_W'(-den) : den[DEN_W-1:0];
    end
    if (state == pmcs_pkg::S_MUL) begin
      mval <= MVAL_W'(out_high);
    end else if (state == pmcs_pkg::S_DIV_MAP && div_rsp.done) begin
      mval <= map_value;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == pmcs_pkg::S_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (levels.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == pmcs_pkg::S_EMIT && out_free) begin
      out_level <= level_value;
    end
  end

  assign levels.valid      = out_valid;
  assign levels.data.level = out_level;

endmodule

`default_nettype wire
